// ===== rtl/dipid_pkg.sv =====
// ----------------------------------------------------------------------------
// dipid_pkg
// Shared types, widths and constants of the dual-wheel incremental PID
// speed regulator.
// ----------------------------------------------------------------------------
package dipid_pkg;

	localparam int unsigned DUTY_CEILING    = 480;
	localparam int unsigned DUTY_FLOOR_INIT = 10;
	localparam int unsigned MIN_GAP_MS      = 8;
	localparam int unsigned SPEED_BITS      = 16;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned DUTY_W    = 9;
	localparam int unsigned GAIN_W    = 24;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned ERR_W     = SPEED_BITS + 1;
	localparam int unsigned DLT_W     = SPEED_BITS + 2;
	localparam int unsigned D2_W      = SPEED_BITS + 3;
	localparam int unsigned SUM_W     = GAIN_W + D2_W + 2;
	localparam int unsigned INC_W     = SUM_W - FRAC_BITS;
	localparam int unsigned ACC_W     = INC_W + 1;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = GAIN_W;

	localparam int unsigned IN_DATA_W  = 4 * SPEED_BITS + TIME_W;
	localparam int unsigned RES_W      = 2 * DUTY_W + 3;
	localparam int unsigned OUT_DATA_W = ((RES_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - RES_W;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(26214);
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(262);
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(3277);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BASE_DUTY     = 2'd0,
		REG_PROP_GAIN     = 2'd1,
		REG_INTEG_GAIN_DT = 2'd2,
		REG_DERIV_GAIN_DT = 2'd3
	} reg_idx_t;

	typedef enum logic {
		MODE_SET_TARGET = 1'b0,
		MODE_TICK       = 1'b1
	} mode_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] deriv;
		logic signed [GAIN_W-1:0] integ;
		logic signed [GAIN_W-1:0] prop;
	} gains_t;

	typedef struct packed {
		logic              reinit;
		logic [DUTY_W-1:0] init_duty;
	} cfg_ctl_t;

	typedef struct packed {
		logic signed [DLT_W-1:0] delta;
		logic signed [ERR_W-1:0] err;
		logic [DUTY_W-1:0]       accum;
	} hist_t;

	typedef struct packed {
		logic [TIME_W-1:0]            now_ms;
		logic signed [SPEED_BITS-1:0] measured_right;
		logic signed [SPEED_BITS-1:0] measured_left;
		logic signed [SPEED_BITS-1:0] target_right;
		logic signed [SPEED_BITS-1:0] target_left;
	} item_t;

	typedef struct packed {
		logic              stopped;
		logic              is_active;
		logic              loop_ran;
		logic [DUTY_W-1:0] right_duty;
		logic [DUTY_W-1:0] left_duty;
	} result_t;

endpackage

// ===== rtl/dipid_regs.sv =====
// ----------------------------------------------------------------------------
// dipid_regs
// Configuration registers: holds the three Q8.16 gains and turns a write of
// the base duty into a re-initialization request with the clamped duty.
// ----------------------------------------------------------------------------
module dipid_regs import dipid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output gains_t                gains,
	output cfg_ctl_t              ctl
);

	gains_t            gains_q;
	logic [DUTY_W-1:0] base_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop  <= PROP_GAIN_RST;
			gains_q.integ <= INTEG_GAIN_RST;
			gains_q.deriv <= DERIV_GAIN_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_PROP_GAIN:     gains_q.prop  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN_DT: gains_q.integ <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN_DT: gains_q.deriv <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		base_raw   = cfg_data[DUTY_W-1:0];
		ctl.reinit = cfg_we && (reg_idx_t'(cfg_addr) == REG_BASE_DUTY);
		if (base_raw > DUTY_W'(DUTY_CEILING)) begin
			ctl.init_duty = DUTY_W'(DUTY_CEILING);
		end else if (base_raw < DUTY_W'(DUTY_FLOOR_INIT)) begin
			ctl.init_duty = DUTY_W'(DUTY_FLOOR_INIT);
		end else begin
			ctl.init_duty = base_raw;
		end
	end

	assign gains = gains_q;

endmodule

// ===== rtl/dipid_wheel.sv =====
// ----------------------------------------------------------------------------
// dipid_wheel
// One incremental PID step for one wheel: error, first and second
// difference, weighted sum, truncation toward zero and clamped accumulation.
// ----------------------------------------------------------------------------
module dipid_wheel import dipid_pkg::*; (
	input  logic signed [SPEED_BITS-1:0] target,
	input  logic signed [SPEED_BITS-1:0] measured,
	input  gains_t                       gains,
	input  hist_t                        hist,
	output hist_t                        hist_nxt
);

	localparam logic signed [ACC_W-1:0] ACC_CEIL = ACC_W'(DUTY_CEILING);
	localparam logic signed [SUM_W-1:0] ROUND_IN = SUM_W'((1 << FRAC_BITS) - 1);

	logic signed [ERR_W-1:0]         err;
	logic signed [DLT_W-1:0]         delta;
	logic signed [D2_W-1:0]          d2;
	logic signed [GAIN_W+DLT_W-1:0]  prod_p;
	logic signed [GAIN_W+ERR_W-1:0]  prod_i;
	logic signed [GAIN_W+D2_W-1:0]   prod_d;
	logic signed [SUM_W-1:0]         sum;
	logic signed [SUM_W-1:0]         sum_adj;
	logic signed [INC_W-1:0]         inc;
	logic signed [ACC_W-1:0]         acc_sum;

	always_comb begin
		err     = ERR_W'(target) - ERR_W'(measured);
		delta   = DLT_W'(err) - DLT_W'(hist.err);
		d2      = D2_W'(delta) - D2_W'(hist.delta);
		prod_p  = gains.prop * delta;
		prod_i  = gains.integ * err;
		prod_d  = gains.deriv * d2;
		sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
		sum_adj = sum[SUM_W-1] ? (sum + ROUND_IN) : sum;
		inc     = sum_adj[SUM_W-1:FRAC_BITS];
		acc_sum = ACC_W'(signed'({1'b0, hist.accum})) + ACC_W'(inc);

		hist_nxt.err   = err;
		hist_nxt.delta = delta;
		if (acc_sum[ACC_W-1]) begin
			hist_nxt.accum = '0;
		end else if (acc_sum > ACC_CEIL) begin
			hist_nxt.accum = DUTY_W'(DUTY_CEILING);
		end else begin
			hist_nxt.accum = acc_sum[DUTY_W-1:0];
		end
	end

endmodule

// ===== rtl/dual_incremental_pid_speed.sv =====
// ----------------------------------------------------------------------------
// dual_incremental_pid_speed
// Two-wheel incremental PID speed regulator with a stream input of set-target
// and tick transactions and a stream output of one result per transaction.
// ----------------------------------------------------------------------------
// An accepted input transaction is held in the input register, and its
// result in the result register; a stalled output holds both.
// Throughput: one transaction per cycle while the output is not stalled;
// the PID step of both wheels is one pass of logic between the two registers.
// Reset: asynchronous, active low; gains take their defaults, history and
// targets clear, and both duties reset to the duty floor of 10.
// ----------------------------------------------------------------------------
module dual_incremental_pid_speed import dipid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// target_left, target_right, measured_left, measured_right, now_ms
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// left_duty, right_duty, loop_ran, is_active, stopped, zero padding
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	gains_t   gains;
	cfg_ctl_t cfg_ctl;

	logic  valid_s1;
	item_t item_s1;
	mode_t mode_s1;
	logic  advance;

	logic    res_valid_q;
	result_t res_q;
	result_t res_d;

	logic signed [SPEED_BITS-1:0] tgt_left_q, tgt_right_q;
	logic signed [SPEED_BITS-1:0] tgt_left_d, tgt_right_d;
	hist_t             hist_left_q, hist_right_q;
	hist_t             hist_left_d, hist_right_d;
	hist_t             step_left, step_right;
	logic [DUTY_W-1:0] duty_left_q, duty_right_q;
	logic [DUTY_W-1:0] duty_left_d, duty_right_d;
	logic              active_q, active_d;
	logic [TIME_W-1:0] last_tick_q, last_tick_d;
	logic [TIME_W-1:0] gap;

	dipid_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.gains    (gains),
		.ctl      (cfg_ctl)
	);

	dipid_wheel u_wheel_left (
		.target   (tgt_left_q),
		.measured (item_s1.measured_left),
		.gains    (gains),
		.hist     (hist_left_q),
		.hist_nxt (step_left)
	);

	dipid_wheel u_wheel_right (
		.target   (tgt_right_q),
		.measured (item_s1.measured_right),
		.gains    (gains),
		.hist     (hist_right_q),
		.hist_nxt (step_right)
	);

	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = res_valid_q;
	assign m_tdata  = {OUT_PAD_W'(0), res_q};

	always_comb begin
		tgt_left_d   = tgt_left_q;
		tgt_right_d  = tgt_right_q;
		hist_left_d  = hist_left_q;
		hist_right_d = hist_right_q;
		duty_left_d  = duty_left_q;
		duty_right_d = duty_right_q;
		active_d     = active_q;
		last_tick_d  = last_tick_q;
		gap          = item_s1.now_ms - last_tick_q;
		res_d        = '0;

		if (mode_s1 == MODE_SET_TARGET) begin
			tgt_left_d  = item_s1.target_left;
			tgt_right_d = item_s1.target_right;
			if (item_s1.target_left == '0 && item_s1.target_right == '0) begin
				hist_left_d   = '0;
				hist_right_d  = '0;
				duty_left_d   = '0;
				duty_right_d  = '0;
				active_d      = 1'b0;
				last_tick_d   = '0;
				res_d.stopped = 1'b1;
			end else begin
				active_d = 1'b1;
			end
		end else if (gap >= TIME_W'(MIN_GAP_MS)) begin
			last_tick_d = item_s1.now_ms;
			if (active_q) begin
				hist_left_d    = step_left;
				hist_right_d   = step_right;
				duty_left_d    = step_left.accum;
				duty_right_d   = step_right.accum;
				res_d.loop_ran = 1'b1;
			end
		end

		res_d.left_duty  = duty_left_d;
		res_d.right_duty = duty_right_d;
		res_d.is_active  = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata);
			mode_s1 <= mode_t'(s_tuser);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_left_q   <= '0;
			tgt_right_q  <= '0;
			hist_left_q  <= '0;
			hist_right_q <= '0;
			duty_left_q  <= DUTY_W'(DUTY_FLOOR_INIT);
			duty_right_q <= DUTY_W'(DUTY_FLOOR_INIT);
			active_q     <= 1'b0;
			last_tick_q  <= '0;
		end else if (cfg_ctl.reinit) begin
			tgt_left_q   <= '0;
			tgt_right_q  <= '0;
			hist_left_q  <= '0;
			hist_right_q <= '0;
			duty_left_q  <= cfg_ctl.init_duty;
			duty_right_q <= cfg_ctl.init_duty;
			active_q     <= 1'b0;
			last_tick_q  <= '0;
		end else if (advance) begin
			tgt_left_q   <= tgt_left_d;
			tgt_right_q  <= tgt_right_d;
			hist_left_q  <= hist_left_d;
			hist_right_q <= hist_right_d;
			duty_left_q  <= duty_left_d;
			duty_right_q <= duty_right_d;
			active_q     <= active_d;
			last_tick_q  <= last_tick_d;
		end
	end

	a_duty_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.left_duty <= DUTY_W'(DUTY_CEILING)
			&& res_q.right_duty <= DUTY_W'(DUTY_CEILING)))
		else $error("Reported duty exceeds the ceiling.");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.stopped) |-> (!res_q.is_active && !res_q.loop_ran
			&& res_q.left_duty == '0 && res_q.right_duty == '0))
		else $error("A full stop did not clear the duties and the active flag.");

	a_ran_active: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.loop_ran) |-> res_q.is_active)
		else $error("The PID update ran while the regulator was inactive.");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("A processed transaction produced no result.");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && !cfg_ctl.reinit) |=> ($stable(active_q) && $stable(last_tick_q)
			&& $stable(duty_left_q) && $stable(duty_right_q)))
		else $error("Regulator state changed without a transaction.");

endmodule
